### hdl/nps_pkg.sv
package nps_pkg;

    // Capacity of the process table.
    localparam int MAX_PROCESSES = 16;

    // Width of a table index and of a count that can hold MAX_PROCESSES itself.
    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    // Field widths of the input and result beats.
    localparam int PRIO_W = 8;
    localparam int ARR_W  = 16;
    localparam int BURST_W = 16;
    localparam int PIDX_W = 5;
    localparam int TIME_W = 22;
    localparam int SUM_W  = 27;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 152;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store the accepted beat
        logic scan_start;  // clear the best candidates and rewind the scan
        logic scan_step;   // compare one table entry
        logic pick;        // latch the chosen process
        logic emit_idle;   // send an idle gap record and move the clock
        logic calc;        // completion and waiting time of the pick
        logic sum;         // turnaround and running wait sum
        logic emit_run;    // send the run record
        logic clear;       // drop the set after its final record
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;   // the scan is at the last loaded entry
        logic gap;         // the chosen process arrives after the clock
        logic out_free;    // the result register can take a record
        logic pick_last;   // the current pick is the last of the set
    } t_sts;

endpackage

### hdl/nonpreemptive_priority_scheduler.sv
// Loading takes one beat per cycle; s_axis_tready is high while the block loads.
// The beat with tlast starts scheduling: for each of the stored processes the
// block scans the whole table, then steps through pick, calc, sum and emit, so
// the next load starts only after the final record is sent, plus any output stall.
// Reset (i_rst_n low, synchronous) empties the set and drops any pending record.
module nonpreemptive_priority_scheduler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Process beats.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata fields from bit 0 up: priority_number, arrival_time, burst_time.
    input  logic [nps_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tlast,   // last_process
    // Schedule records.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata fields from bit 0 up: process_index, start_time, completion_time,
    // turnaround, waiting, total_waiting, total_turnaround, zero padding.
    output logic [nps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tuser,   // is_idle
    output logic                               m_axis_tlast    // final_record
);

    nps_pkg::t_cmd cmd;
    nps_pkg::t_sts sts;

    logic [nps_pkg::PIDX_W-1:0] process_index;
    logic [nps_pkg::TIME_W-1:0] start_time;
    logic [nps_pkg::TIME_W-1:0] completion_time;
    logic [nps_pkg::TIME_W-1:0] turnaround;
    logic [nps_pkg::TIME_W-1:0] waiting;
    logic [nps_pkg::SUM_W-1:0]  total_waiting;
    logic [nps_pkg::SUM_W-1:0]  total_turnaround;

    // The controller sequences load, scan, pick, and the two arithmetic steps;
    // it holds off the next scan until the result register frees up.
    nps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    // The datapath holds the process table, the scan candidates, the clock,
    // the running sums and the result register.
    nps_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_priority_number  (s_axis_tdata[7:0]),
        .i_arrival_time     (s_axis_tdata[23:8]),
        .i_burst_time       (s_axis_tdata[39:24]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_is_idle          (m_axis_tuser),
        .o_process_index    (process_index),
        .o_start_time       (start_time),
        .o_completion_time  (completion_time),
        .o_turnaround       (turnaround),
        .o_waiting          (waiting),
        .o_total_waiting    (total_waiting),
        .o_total_turnaround (total_turnaround),
        .o_final_record     (m_axis_tlast)
    );

    // Pack the record fields, lowest field first, padded to whole bytes.
    assign m_axis_tdata = {5'b0, total_turnaround, total_waiting, waiting,
                           turnaround, completion_time, start_time, process_index};

endmodule

### hdl/nps_ctrl.sv
module nps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  nps_pkg::t_sts i_sts,
    output nps_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK,
        ST_CALC,
        ST_SUM,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                o_cmd.load       = in_acc;
                o_cmd.scan_start = in_acc && i_in_last;
                if (in_acc && i_in_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                o_cmd.pick      = 1'b1;
                o_cmd.emit_idle = i_sts.gap && i_sts.out_free;
                if (!i_sts.gap || i_sts.out_free) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_run = 1'b1;
                    if (i_sts.pick_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_LOAD;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/nps_dp.sv
module nps_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nps_pkg::t_cmd                 i_cmd,
    output nps_pkg::t_sts                 o_sts,
    input  logic [nps_pkg::PRIO_W-1:0]    i_priority_number,
    input  logic [nps_pkg::ARR_W-1:0]     i_arrival_time,
    input  logic [nps_pkg::BURST_W-1:0]   i_burst_time,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_is_idle,
    output logic [nps_pkg::PIDX_W-1:0]    o_process_index,
    output logic [nps_pkg::TIME_W-1:0]    o_start_time,
    output logic [nps_pkg::TIME_W-1:0]    o_completion_time,
    output logic [nps_pkg::TIME_W-1:0]    o_turnaround,
    output logic [nps_pkg::TIME_W-1:0]    o_waiting,
    output logic [nps_pkg::SUM_W-1:0]     o_total_waiting,
    output logic [nps_pkg::SUM_W-1:0]     o_total_turnaround,
    output logic                          o_final_record
);

    // Process table; entries at or above the load count are never read.
    logic [nps_pkg::PRIO_W-1:0]  r_prio  [nps_pkg::MAX_PROCESSES];
    logic [nps_pkg::ARR_W-1:0]   r_arr   [nps_pkg::MAX_PROCESSES];
    logic [nps_pkg::BURST_W-1:0] r_burst [nps_pkg::MAX_PROCESSES];
    logic [nps_pkg::MAX_PROCESSES-1:0] r_done;

    logic [nps_pkg::CNT_W-1:0]  r_count;
    logic [nps_pkg::CNT_W-1:0]  r_picks;
    logic [nps_pkg::IDX_W-1:0]  r_scan;
    logic [nps_pkg::TIME_W-1:0] r_time;
    logic [nps_pkg::SUM_W-1:0]  r_wsum;
    logic [nps_pkg::SUM_W-1:0]  r_tsum;

    // Best ready candidate: priority, then arrival, then lowest index.
    logic                        r_rdy_found;
    logic [nps_pkg::PRIO_W-1:0]  r_rdy_prio;
    logic [nps_pkg::ARR_W-1:0]   r_rdy_arr;
    logic [nps_pkg::BURST_W-1:0] r_rdy_burst;
    logic [nps_pkg::IDX_W-1:0]   r_rdy_idx;

    // Best candidate overall when nothing is ready: arrival, then priority.
    logic                        r_fb_found;
    logic [nps_pkg::PRIO_W-1:0]  r_fb_prio;
    logic [nps_pkg::ARR_W-1:0]   r_fb_arr;
    logic [nps_pkg::BURST_W-1:0] r_fb_burst;
    logic [nps_pkg::IDX_W-1:0]   r_fb_idx;

    logic [nps_pkg::ARR_W-1:0]   r_sel_arr;
    logic [nps_pkg::BURST_W-1:0] r_sel_burst;
    logic [nps_pkg::IDX_W-1:0]   r_sel_idx;

    logic [nps_pkg::TIME_W-1:0] r_run_start;
    logic [nps_pkg::TIME_W-1:0] r_run_done;
    logic [nps_pkg::TIME_W-1:0] r_run_wt;
    logic [nps_pkg::TIME_W-1:0] r_run_tat;

    logic                        r_ov;

    logic [nps_pkg::PRIO_W-1:0]  e_prio;
    logic [nps_pkg::ARR_W-1:0]   e_arr;
    logic [nps_pkg::BURST_W-1:0] e_burst;
    logic                        e_done;
    logic                        e_ready;
    logic                        rdy_better;
    logic                        fb_better;
    logic [nps_pkg::ARR_W-1:0]   c_arr;
    logic [nps_pkg::BURST_W-1:0] c_burst;
    logic [nps_pkg::IDX_W-1:0]   c_idx;
    logic [nps_pkg::SUM_W-1:0]   tsum_next;

    assign e_prio  = r_prio[r_scan];
    assign e_arr   = r_arr[r_scan];
    assign e_burst = r_burst[r_scan];
    assign e_done  = r_done[r_scan];
    assign e_ready = (nps_pkg::TIME_W'(e_arr) <= r_time);

    assign rdy_better = !e_done && e_ready &&
        (!r_rdy_found || (e_prio < r_rdy_prio) ||
         ((e_prio == r_rdy_prio) && (e_arr < r_rdy_arr)));
    assign fb_better = !e_done &&
        (!r_fb_found || (e_arr < r_fb_arr) ||
         ((e_arr == r_fb_arr) && (e_prio < r_fb_prio)));

    // Choice after a full scan.
    assign c_arr   = r_rdy_found ? r_rdy_arr   : r_fb_arr;
    assign c_burst = r_rdy_found ? r_rdy_burst : r_fb_burst;
    assign c_idx   = r_rdy_found ? r_rdy_idx   : r_fb_idx;

    assign tsum_next = r_tsum + nps_pkg::SUM_W'(r_run_tat);

    assign o_sts.scan_last = (nps_pkg::CNT_W'(r_scan) == (r_count - 1'b1));
    assign o_sts.gap       = (nps_pkg::TIME_W'(c_arr) > r_time);
    assign o_sts.out_free  = !r_ov || i_out_ready;
    assign o_sts.pick_last = (r_picks == (r_count - 1'b1));

    assign o_out_valid = r_ov;

    // Table writes; payload only, no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < nps_pkg::CNT_W'(nps_pkg::MAX_PROCESSES))) begin
            r_prio[r_count[nps_pkg::IDX_W-1:0]]  <= i_priority_number;
            r_arr[r_count[nps_pkg::IDX_W-1:0]]   <= i_arrival_time;
            r_burst[r_count[nps_pkg::IDX_W-1:0]] <= i_burst_time;
        end
    end

    // Control and scheduling state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_count     <= '0;
            r_picks     <= '0;
            r_scan      <= '0;
            r_time      <= '0;
            r_wsum      <= '0;
            r_tsum      <= '0;
            r_rdy_found <= 1'b0;
            r_fb_found  <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cmd.load && (r_count < nps_pkg::CNT_W'(nps_pkg::MAX_PROCESSES))) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan      <= '0;
                r_rdy_found <= 1'b0;
                r_fb_found  <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_scan <= r_scan + 1'b1;
                if (rdy_better) begin
                    r_rdy_found <= 1'b1;
                end
                if (fb_better) begin
                    r_fb_found <= 1'b1;
                end
            end
            if (i_cmd.emit_idle) begin
                r_time <= nps_pkg::TIME_W'(c_arr);
            end
            if (i_cmd.calc) begin
                r_done[r_sel_idx] <= 1'b1;
            end
            if (i_cmd.sum) begin
                r_wsum <= r_wsum + nps_pkg::SUM_W'(r_run_wt);
            end
            if (i_cmd.emit_run) begin
                r_time  <= r_run_done;
                r_tsum  <= tsum_next;
                r_picks <= r_picks + 1'b1;
            end
            if (i_cmd.clear) begin
                r_done  <= '0;
                r_count <= '0;
                r_picks <= '0;
                r_time  <= '0;
                r_wsum  <= '0;
                r_tsum  <= '0;
            end
            if (i_cmd.emit_idle || i_cmd.emit_run) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Candidate, selection and arithmetic payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && rdy_better) begin
            r_rdy_prio  <= e_prio;
            r_rdy_arr   <= e_arr;
            r_rdy_burst <= e_burst;
            r_rdy_idx   <= r_scan;
        end
        if (i_cmd.scan_step && fb_better) begin
            r_fb_prio  <= e_prio;
            r_fb_arr   <= e_arr;
            r_fb_burst <= e_burst;
            r_fb_idx   <= r_scan;
        end
        if (i_cmd.pick) begin
            r_sel_arr   <= c_arr;
            r_sel_burst <= c_burst;
            r_sel_idx   <= c_idx;
        end
        if (i_cmd.calc) begin
            // Waiting time equals start minus arrival.
            r_run_start <= r_time;
            r_run_done  <= r_time + nps_pkg::TIME_W'(r_sel_burst);
            r_run_wt    <= r_time - nps_pkg::TIME_W'(r_sel_arr);
        end
        if (i_cmd.sum) begin
            r_run_tat <= r_run_done - nps_pkg::TIME_W'(r_sel_arr);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_idle) begin
            o_is_idle          <= 1'b1;
            o_process_index    <= '0;
            o_start_time       <= r_time;
            o_completion_time  <= nps_pkg::TIME_W'(c_arr);
            o_turnaround       <= '0;
            o_waiting          <= '0;
            o_total_waiting    <= '0;
            o_total_turnaround <= '0;
            o_final_record     <= 1'b0;
        end else if (i_cmd.emit_run) begin
            o_is_idle          <= 1'b0;
            o_process_index    <= nps_pkg::PIDX_W'(r_sel_idx);
            o_start_time       <= r_run_start;
            o_completion_time  <= r_run_done;
            o_turnaround       <= r_run_tat;
            o_waiting          <= r_run_wt;
            o_total_waiting    <= o_sts.pick_last ? r_wsum : '0;
            o_total_turnaround <= o_sts.pick_last ? tsum_next : '0;
            o_final_record     <= o_sts.pick_last;
        end
    end

endmodule
